// ===== rtl/rtd_sample_scheduler_spike_filter_macros.svh =====
// ---------------------------------------------------------------------------
// RTD sample scheduler assertion macros
// Shared concurrent assertion forms for the scheduler and spike filter.
// ---------------------------------------------------------------------------
`ifndef RTD_SAMPLE_SCHEDULER_SPIKE_FILTER_MACROS_SVH
`define RTD_SAMPLE_SCHEDULER_SPIKE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rssf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rssf assertion failed");

`endif

// ===== rtl/rssf_pkg.sv =====
// ---------------------------------------------------------------------------
// RTD sample scheduler package
// Register indexes, reset values and shared types.
// ---------------------------------------------------------------------------
package rssf_pkg;

  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned FaultBits   = 8;
  localparam int unsigned RejBits     = 4;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_READ_INTERVAL = 3'd0,
    REG_SETTLE        = 3'd1,
    REG_BAND_LOW      = 3'd2,
    REG_BAND_HIGH     = 3'd3,
    REG_JUMP_LIMIT    = 3'd4,
    REG_REJECT_LIMIT  = 3'd5
  } cfg_reg_e;

  localparam logic        [15:0] ResetReadInterval = 16'd1000;
  localparam logic        [15:0] ResetSettle       = 16'd100;
  localparam logic signed [15:0] ResetBandLow      = 16'sd0;
  localparam logic signed [15:0] ResetBandHigh     = 16'sd2560;
  localparam logic        [15:0] ResetJumpLimit    = 16'd400;
  localparam logic        [RejBits-1:0] ResetRejectLimit = 4'd10;

  // Opcode of an input beat.
  localparam logic OpTick   = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic        [15:0]        read_interval_ms;
    logic        [15:0]        settle_ms;
    logic signed [15:0]        band_low;
    logic signed [15:0]        band_high;
    logic        [15:0]        jump_limit;
    logic        [RejBits-1:0] reject_limit;
  } cfg_t;

  // Events from the scheduler for one beat.
  typedef struct packed {
    logic bias_on;
    logic read_request;
    logic clear_fault;
    logic good_sample;
  } sched_ev_t;

endpackage

// ===== rtl/rssf_if.sv =====
// ---------------------------------------------------------------------------
// RTD sample scheduler channel interfaces
// Valid/ready channels for input beats and result beats.
// ---------------------------------------------------------------------------
interface rssf_in_if #(
  parameter int TEMP_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic signed [TEMP_BITS-1:0] sample_temp;
  logic        [7:0]           sample_fault;

  modport source (output valid, op, sample_temp, sample_fault, input ready);
  modport sink   (input valid, op, sample_temp, sample_fault, output ready);
endinterface

interface rssf_out_if #(
  parameter int TEMP_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        bias_on;
  logic                        read_request;
  logic                        clear_fault;
  logic                        accepted;
  logic                        rejected;
  logic        [7:0]           fault_seen;
  logic signed [TEMP_BITS-1:0] held_temp;
  logic                        held_valid;
  logic        [3:0]           reject_level;

  modport source (output valid, bias_on, read_request, clear_fault, accepted, rejected,
                  fault_seen, held_temp, held_valid, reject_level, input ready);
  modport sink   (input valid, bias_on, read_request, clear_fault, accepted, rejected,
                  fault_seen, held_temp, held_valid, reject_level, output ready);
endinterface

// ===== rtl/rssf_sched.sv =====
// ---------------------------------------------------------------------------
// RTD sample scheduler conversion timing
// Millisecond timer, bias control and read request sequencing.
// ---------------------------------------------------------------------------
module rssf_sched #(
  parameter int TIMER_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                op_i,
  input  logic [rssf_pkg::FaultBits-1:0]      fault_i,
  input  logic [rssf_pkg::CfgDataBits-1:0]    read_interval_i,
  input  logic [rssf_pkg::CfgDataBits-1:0]    settle_i,
  output rssf_pkg::sched_ev_t                 ev_o,
  output logic [rssf_pkg::FaultBits-1:0]      fault_seen_o
);
  import rssf_pkg::*;

  localparam int TW = (TIMER_BITS > CfgDataBits) ? TIMER_BITS : CfgDataBits;
  localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                  meas_q, meas_d;
  logic                  await_q, await_d;
  logic                  bias_q, bias_d;

  assign elapsed_inc = (elapsed_q == TimerMax) ? elapsed_q : elapsed_q + 1'b1;

  always_comb begin
    elapsed_d    = elapsed_q;
    meas_d       = meas_q;
    await_d      = await_q;
    bias_d       = bias_q;
    ev_o         = '0;
    fault_seen_o = '0;
    if (op_i == OpTick) begin
      elapsed_d = elapsed_inc;
      if (!meas_q) begin
        if (TW'(elapsed_inc) > TW'(read_interval_i)) begin
          elapsed_d = '0;
          bias_d    = 1'b1;
          meas_d    = 1'b1;
        end
      end else if (!await_q && (TW'(elapsed_inc) >= TW'(settle_i))) begin
        ev_o.read_request = 1'b1;
        await_d           = 1'b1;
      end
    end else if (await_q) begin
      await_d = 1'b0;
      bias_d  = 1'b0;
      if (fault_i != '0) begin
        ev_o.clear_fault = 1'b1;
        fault_seen_o     = fault_i;
      end else begin
        ev_o.good_sample = 1'b1;
        meas_d           = 1'b0;
      end
    end
    ev_o.bias_on = bias_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      meas_q    <= 1'b0;
      await_q   <= 1'b0;
      bias_q    <= 1'b0;
    end else if (step_i) begin
      elapsed_q <= elapsed_d;
      meas_q    <= meas_d;
      await_q   <= await_d;
      bias_q    <= bias_d;
    end
  end

endmodule

// ===== rtl/rssf_filter.sv =====
// ---------------------------------------------------------------------------
// RTD sample scheduler spike filter
// Band check, jump limit and saturating reject count on good samples.
// ---------------------------------------------------------------------------
module rssf_filter #(
  parameter int TEMP_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic                               good_i,
  input  logic signed [TEMP_BITS-1:0]        temp_i,
  input  rssf_pkg::cfg_t                     cfg_i,
  output logic                               accepted_o,
  output logic                               rejected_o,
  output logic signed [TEMP_BITS-1:0]        held_temp_o,
  output logic                               held_valid_o,
  output logic [rssf_pkg::RejBits-1:0]       reject_level_o
);
  import rssf_pkg::*;

  localparam int CW = (TEMP_BITS > CfgDataBits) ? TEMP_BITS : CfgDataBits;
  localparam int DW = TEMP_BITS + 1;
  localparam int JW = (DW > CfgDataBits) ? DW : CfgDataBits;

  logic signed [TEMP_BITS-1:0] held_q, held_d;
  logic                        seeded_q, seeded_d;
  logic [RejBits-1:0]          rc_q, rc_d;

  logic signed [CW-1:0] t_x, lo_x, hi_x;
  logic signed [DW-1:0] diff;
  logic        [DW-1:0] mag;
  logic                 in_band, small_jump, take;

  assign t_x  = CW'(temp_i);
  assign lo_x = CW'(cfg_i.band_low);
  assign hi_x = CW'(cfg_i.band_high);
  assign in_band = (t_x >= lo_x) && (t_x <= hi_x);

  // Difference fits one extra bit, so the magnitude is exact.
  assign diff = DW'(temp_i) - DW'(held_q);
  assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign small_jump = !seeded_q || (JW'(mag) <= JW'(cfg_i.jump_limit));
  assign take = in_band && (small_jump || (rc_q >= cfg_i.reject_limit));

  always_comb begin
    held_d     = held_q;
    seeded_d   = seeded_q;
    rc_d       = rc_q;
    accepted_o = 1'b0;
    rejected_o = 1'b0;
    if (good_i) begin
      if (take) begin
        held_d     = temp_i;
        seeded_d   = 1'b1;
        rc_d       = '0;
        accepted_o = 1'b1;
      end else begin
        if (rc_q < cfg_i.reject_limit) begin
          rc_d = rc_q + 1'b1;
        end
        rejected_o = 1'b1;
      end
    end
  end

  assign held_temp_o    = held_d;
  assign held_valid_o   = seeded_d;
  assign reject_level_o = rc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      seeded_q <= 1'b0;
      rc_q     <= '0;
    end else if (step_i) begin
      held_q   <= held_d;
      seeded_q <= seeded_d;
      rc_q     <= rc_d;
    end
  end

endmodule

// ===== rtl/rtd_sample_scheduler_spike_filter.sv =====
// Schedules RTD conversions from 1 ms tick beats and filters the returned
// samples for plausibility and spikes. Every input beat, tick or sample,
// gives exactly one result beat. The block takes one beat per clock cycle
// unless backpressure on the result side holds it. A taken beat waits in
// the input register, and the single state-update path through the timer
// and the filter completes as the beat moves into the result register,
// which then offers the result beat.
// Backpressure on the result side stalls both registers, and a new input
// beat is still taken while a finished result waits, as long as the input
// register is empty. Configuration writes take effect at once and are
// expected only while no beats are in flight.
// ---------------------------------------------------------------------------
// RTD sample scheduler with spike filter, top level
// Input register, scheduler, filter, result register and configuration.
// ---------------------------------------------------------------------------
`include "rtd_sample_scheduler_spike_filter_macros.svh"

module rtd_sample_scheduler_spike_filter #(
  parameter int TEMP_BITS  = 16,
  parameter int TIMER_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rssf_in_if.sink                           in_bus,
  rssf_out_if.source                        out_bus,
  input  logic                              cfg_we_i,
  input  logic [rssf_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [rssf_pkg::CfgDataBits-1:0]  cfg_wdata_i
);
  import rssf_pkg::*;

  // Configuration registers, written directly by the register port.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.read_interval_ms <= ResetReadInterval;
      cfg_q.settle_ms        <= ResetSettle;
      cfg_q.band_low         <= ResetBandLow;
      cfg_q.band_high        <= ResetBandHigh;
      cfg_q.jump_limit       <= ResetJumpLimit;
      cfg_q.reject_limit     <= ResetRejectLimit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_READ_INTERVAL: cfg_q.read_interval_ms <= cfg_wdata_i;
        REG_SETTLE:        cfg_q.settle_ms        <= cfg_wdata_i;
        REG_BAND_LOW:      cfg_q.band_low         <= $signed(cfg_wdata_i);
        REG_BAND_HIGH:     cfg_q.band_high        <= $signed(cfg_wdata_i);
        REG_JUMP_LIMIT:    cfg_q.jump_limit       <= cfg_wdata_i;
        REG_REJECT_LIMIT:  cfg_q.reject_limit     <= cfg_wdata_i[RejBits-1:0];
        default: ; // Writes beyond the register list are dropped.
      endcase
    end
  end

  // The input register advances whenever the result register is free or
  // is being emptied in this cycle, so the state update happens exactly
  // once per beat, at the edge where the beat moves into the result stage.
  logic                        in_valid_q;
  logic                        in_op_q;
  logic signed [TEMP_BITS-1:0] in_temp_q;
  logic [FaultBits-1:0]        in_fault_q;
  logic                        out_valid_q;
  logic                        step;
  logic                        in_take;

  assign step    = in_valid_q && (!out_valid_q || out_bus.ready);
  assign in_take = in_bus.valid && in_bus.ready;
  assign in_bus.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_q <= in_bus.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q    <= in_bus.op;
      in_temp_q  <= in_bus.sample_temp;
      in_fault_q <= in_bus.sample_fault;
    end
  end

  // Timer and bias sequencing.
  sched_ev_t            ev;
  logic [FaultBits-1:0] fault_seen;

  rssf_sched #(
    .TIMER_BITS (TIMER_BITS)
  ) u_sched (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .op_i            (in_op_q),
    .fault_i         (in_fault_q),
    .read_interval_i (cfg_q.read_interval_ms),
    .settle_i        (cfg_q.settle_ms),
    .ev_o            (ev),
    .fault_seen_o    (fault_seen)
  );

  // Plausibility and spike filter; it only acts on a requested, fault-free
  // sample.
  logic                        f_acc, f_rej, f_valid;
  logic signed [TEMP_BITS-1:0] f_held;
  logic [RejBits-1:0]          f_level;

  rssf_filter #(
    .TEMP_BITS (TEMP_BITS)
  ) u_filter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .good_i         (ev.good_sample),
    .temp_i         (in_temp_q),
    .cfg_i          (cfg_q),
    .accepted_o     (f_acc),
    .rejected_o     (f_rej),
    .held_temp_o    (f_held),
    .held_valid_o   (f_valid),
    .reject_level_o (f_level)
  );

  // Result register: loads the post-beat state and event pulses.
  logic                        bias_q, req_q, clr_q, acc_q, rej_q, hv_q;
  logic [FaultBits-1:0]        fault_q;
  logic signed [TEMP_BITS-1:0] held_q;
  logic [RejBits-1:0]          level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_bus.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      bias_q  <= ev.bias_on;
      req_q   <= ev.read_request;
      clr_q   <= ev.clear_fault;
      acc_q   <= f_acc;
      rej_q   <= f_rej;
      fault_q <= fault_seen;
      held_q  <= f_held;
      hv_q    <= f_valid;
      level_q <= f_level;
    end
  end

  assign out_bus.valid        = out_valid_q;
  assign out_bus.bias_on      = bias_q;
  assign out_bus.read_request = req_q;
  assign out_bus.clear_fault  = clr_q;
  assign out_bus.accepted     = acc_q;
  assign out_bus.rejected     = rej_q;
  assign out_bus.fault_seen   = fault_q;
  assign out_bus.held_temp    = held_q;
  assign out_bus.held_valid   = hv_q;
  assign out_bus.reject_level = level_q;

  // A beat waiting in the input register keeps its contents until it moves.
  `RSSF_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !step, in_valid_q && $stable(in_op_q) && $stable(in_temp_q) && $stable(in_fault_q))
  // An accepted sample always seeds the held value and clears the count.
  `RSSF_ASSERT_NOW(a_acc_state, clk_i, rst_ni, out_valid_q && acc_q, hv_q && (level_q == '0) && !rej_q)
  // A fault clear reports the nonzero fault byte and drops the bias.
  `RSSF_ASSERT_NOW(a_clr_fault, clk_i, rst_ni, out_valid_q && clr_q, (fault_q != '0) && !bias_q)
  // A finished sample, good or faulty, never coincides with a read request.
  // The bias may be off here, since a fault clear keeps the measurement open.
  `RSSF_ASSERT_NOW(a_req_excl, clk_i, rst_ni, out_valid_q && req_q, !acc_q && !rej_q && !clr_q)

endmodule
